// ----- src/twt_pkg.sv -----
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types and constants of the timing wheel timer.
// ----------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

  localparam int DELAY_W   = 31;
  localparam int ROUND_W   = 32;
  localparam int CFG_W     = 7;
  localparam int ID_OUT_W  = 6;
  localparam int DIV_W     = 32;
  localparam int QUOT_W    = 12;
  localparam int STEP_W    = 4;
  localparam int SPOKE_W   = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [DELAY_W-1:0] MIN_DELAY_US = 31'd100;
  localparam logic [DIV_W-1:0]   US_PER_SEC   = 32'd1000000;
  localparam logic [CFG_W-1:0]   SLOTS_RESET  = 7'd60;

  // seconds = (delay * SEC_RECIP) >> SEC_SHIFT, exact for any 31-bit delay
  localparam logic [DELAY_W-1:0] SEC_RECIP    = 31'd1125899907;
  localparam int                 SEC_SHIFT    = 50;

  localparam logic [0:0] REG_WHEEL_SLOTS = 1'b0;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_EXPIRED = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

endpackage

`default_nettype wire

// ----- src/twt_in_if.sv -----
// ----------------------------------------------------------------------------
// twt_in_if
// Request channel: add timer or one-second tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface twt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [twt_pkg::DELAY_W-1:0]  delay_us;
  logic [twt_pkg::DELAY_W-1:0]  period_us;

  modport source (output valid, opcode, delay_us, period_us, input ready);
  modport sink   (input valid, opcode, delay_us, period_us, output ready);
endinterface

`default_nettype wire

// ----- src/twt_out_if.sv -----
// ----------------------------------------------------------------------------
// twt_out_if
// Result channel: add acknowledge or timer expiry.
// ----------------------------------------------------------------------------
`default_nettype none

interface twt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [twt_pkg::ID_OUT_W-1:0]  timer_id;
  logic                          status;
  logic                          last;

  modport source (output valid, kind, timer_id, status, last, input ready);
  modport sink   (input valid, kind, timer_id, status, last, output ready);
endinterface

`default_nettype wire

// ----- src/twt_div.sv -----
// ----------------------------------------------------------------------------
// twt_div
// Restoring divider, one quotient bit per cycle, for short quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [twt_pkg::DIV_W-1:0]     dividend,
  input  wire logic [twt_pkg::DIV_W-1:0]     divisor,
  output logic                               done,
  output logic      [twt_pkg::QUOT_W-1:0]    quot,
  output logic      [twt_pkg::DIV_W-1:0]     rem
);

  localparam int WIDE_W = twt_pkg::DIV_W + twt_pkg::QUOT_W;

  logic                          busy_r;
  logic                          done_r;
  logic [twt_pkg::STEP_W-1:0]    step_r;
  logic [twt_pkg::DIV_W-1:0]     rem_r;
  logic [twt_pkg::DIV_W-1:0]     dvs_r;
  logic [twt_pkg::QUOT_W-1:0]    quot_r;
  logic [WIDE_W-1:0]             shifted;
  logic                          take;

  assign shifted = {{twt_pkg::QUOT_W{1'b0}}, dvs_r} << step_r;
  assign take    = {{twt_pkg::QUOT_W{1'b0}}, rem_r} >= shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= divisor;
      quot_r <= '0;
      step_r <= twt_pkg::STEP_W'(twt_pkg::QUOT_W - 1);
    end else if (busy_r) begin
      if (take) begin
        rem_r          <= rem_r - shifted[twt_pkg::DIV_W-1:0];
        quot_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- src/timing_wheel_timer.sv -----
// ----------------------------------------------------------------------------
// timing_wheel_timer
// Hashed timing wheel over a table of timer entries held in one memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        opcode, delay_us, period_us
//  out_ch    out  valid/ready        kind, timer_id, status, last
//  APB       in   psel/penable       paddr, pwdata, prdata (wheel_slots)
//
//  Add: scaled to seconds, placed by the slot divider, then loaded into the
//  output register. Table full: answered without a placement.
//  Tick: a scan of the whole table, then per expiry a pick and a read;
//  a periodic entry is re-armed through the slot divider.
//  One item at a time; a result waits in the output register while the
//  next item is taken, and a held output stalls the block. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_timer #(
  parameter int TIMERS    = 64,
  parameter int MAX_SLOTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  twt_in_if.sink                             in_ch,
  twt_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [twt_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [twt_pkg::PDATA_W-1:0]   pwdata,
  output logic      [twt_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int ID_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int ENT_W  = SLOT_W + twt_pkg::ROUND_W + twt_pkg::DELAY_W;
  localparam int PROD_W = 2 * twt_pkg::DELAY_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FULL  = 9'b000000010,
    S_SEC   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_ACK   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_PICK  = 9'b010000000,
    S_READ  = 9'b100000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [TIMERS-1:0]               valid_r;
  logic [TIMERS-1:0]               hit_r;
  logic [ENT_W-1:0]                mem [TIMERS];
  logic [ENT_W-1:0]                mem_q_r;
  logic                            cmp_r;
  logic [ID_W-1:0]                 cmp_idx_r;
  logic [ID_W-1:0]                 scan_r;
  logic [ID_W-1:0]                 id_r;
  logic [twt_pkg::DELAY_W-1:0]     per_r;
  logic [twt_pkg::DELAY_W-1:0]     dly_r;
  logic                            rearm_r;
  logic [twt_pkg::CFG_W-1:0]       slots_r;
  logic [twt_pkg::SPOKE_W-1:0]     spoke_r;
  logic                            spoke_neg_r;
  logic [twt_pkg::ROUND_W-1:0]     round_r;

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [ID_W-1:0]                 out_id_r;
  logic                            out_status_r;
  logic                            out_last_r;

  logic [twt_pkg::CFG_W-1:0]       slots_n;
  logic                            in_xfer;
  logic                            out_free;
  logic                            any_free;
  logic [ID_W-1:0]                 free_idx;
  logic [ID_W-1:0]                 hit_idx;
  logic [twt_pkg::SPOKE_W-1:0]     spoke_inc;

  logic                            div_start;
  logic [twt_pkg::DIV_W-1:0]       div_a;
  logic [twt_pkg::DIV_W-1:0]       div_b;
  logic                            div_done;
  logic [twt_pkg::QUOT_W-1:0]      div_q;
  logic [twt_pkg::DIV_W-1:0]       div_r;
  logic [twt_pkg::DELAY_W-1:0]     clamp_src;
  logic [twt_pkg::DELAY_W-1:0]     clamped;
  logic [PROD_W-1:0]               sec_prod;
  logic [twt_pkg::QUOT_W-1:0]      sec_q;
  logic [twt_pkg::DIV_W-1:0]       pos;

  logic                            rd_en;
  logic [ID_W-1:0]                 rd_addr;
  logic                            we;
  logic [ENT_W-1:0]                wdata;

  logic [SLOT_W-1:0]               q_slot;
  logic [twt_pkg::ROUND_W-1:0]     q_round;
  logic [twt_pkg::DELAY_W-1:0]     q_per;
  logic                            emit_last;
  logic                            emit;

  always_comb begin
    if (slots_r == '0) begin
      slots_n = twt_pkg::CFG_W'(1);
    end else if (slots_r > twt_pkg::CFG_W'(MAX_SLOTS)) begin
      slots_n = twt_pkg::CFG_W'(MAX_SLOTS);
    end else begin
      slots_n = slots_r;
    end
  end

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    hit_idx  = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = ID_W'(i);
      end
      if (hit_r[i]) begin
        hit_idx = ID_W'(i);
      end
    end
  end

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign spoke_inc = spoke_r + 1'b1;

  assign {q_slot, q_round, q_per} = mem_q_r;

  // config
  assign pready = 1'b1;
  assign prdata = {{(twt_pkg::PDATA_W - twt_pkg::CFG_W){1'b0}}, slots_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= twt_pkg::SLOTS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == twt_pkg::REG_WHEEL_SLOTS) begin
      slots_r <= pwdata[twt_pkg::CFG_W-1:0];
    end
  end

  // seconds by reciprocal multiply, then slot and round through the divider
  assign clamp_src = (state_r == S_IDLE) ? in_ch.delay_us : q_per;
  assign clamped   = (clamp_src < twt_pkg::MIN_DELAY_US) ? twt_pkg::MIN_DELAY_US
                                                         : clamp_src;
  assign sec_prod  = PROD_W'(dly_r) * PROD_W'(twt_pkg::SEC_RECIP);
  assign sec_q     = sec_prod[twt_pkg::SEC_SHIFT +: twt_pkg::QUOT_W];
  assign pos = spoke_neg_r ? twt_pkg::DIV_W'(sec_q)
             : twt_pkg::DIV_W'(sec_q) + twt_pkg::DIV_W'(spoke_r) + twt_pkg::DIV_W'(1);

  assign div_start = (state_r == S_SEC);
  assign div_a     = pos;
  assign div_b     = twt_pkg::DIV_W'(slots_n);

  twt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // memory
  assign rd_en   = (state_r == S_SCAN) || (state_r == S_PICK && hit_r != '0);
  assign rd_addr = (state_r == S_SCAN) ? scan_r : hit_idx;
  assign we      = (state_r == S_DIV) && div_done;
  assign wdata   = {div_r[SLOT_W-1:0], round_r + twt_pkg::ROUND_W'(div_q), per_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[id_r] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // state machine
  assign emit      = (state_r == S_READ) && out_free;
  assign emit_last = (hit_r & ~(TIMERS'(1) << id_r)) == '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.opcode == twt_pkg::OP_TICK) begin
            state_nxt = S_SCAN;
          end else if (any_free) begin
            state_nxt = S_SEC;
          end else begin
            state_nxt = S_FULL;
          end
        end
      end
      S_FULL:  if (out_free) state_nxt = S_IDLE;
      S_SEC:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = rearm_r ? S_PICK : S_ACK;
      S_ACK:   if (out_free) state_nxt = S_IDLE;
      S_SCAN:  if (scan_r == ID_W'(TIMERS - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_PICK;
      S_PICK:  state_nxt = (hit_r == '0) ? S_IDLE : S_READ;
      S_READ: begin
        if (out_free) begin
          state_nxt = (q_per != '0) ? S_SEC : S_PICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      hit_r       <= '0;
      cmp_r       <= 1'b0;
      spoke_r     <= '0;
      spoke_neg_r <= 1'b1;
      round_r     <= '0;
      rearm_r     <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cmp_r   <= (state_r == S_SCAN);
      if (state_r == S_IDLE && in_xfer) begin
        if (in_ch.opcode == twt_pkg::OP_TICK) begin
          hit_r       <= '0;
          scan_r      <= '0;
          rearm_r     <= 1'b1;
          spoke_neg_r <= 1'b0;
          if (spoke_neg_r) begin
            spoke_r <= '0;
          end else if (spoke_inc >= slots_n) begin
            spoke_r <= '0;
            round_r <= round_r + 1'b1;
          end else begin
            spoke_r <= spoke_inc;
          end
        end else begin
          rearm_r <= 1'b0;
        end
      end
      if (state_r == S_SCAN) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmp_r) begin
        hit_r[cmp_idx_r] <= valid_r[cmp_idx_r]
                         && twt_pkg::SPOKE_W'(q_slot) == spoke_r
                         && q_round == round_r;
      end
      if (emit) begin
        hit_r[id_r] <= 1'b0;
        if (q_per == '0) begin
          valid_r[id_r] <= 1'b0;
        end
      end
      if (we) begin
        valid_r[id_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_r;
    if (state_r == S_IDLE && in_xfer) begin
      id_r  <= free_idx;
      per_r <= in_ch.period_us;
      dly_r <= clamped;
    end else if (state_r == S_PICK) begin
      id_r <= hit_idx;
    end else if (emit) begin
      per_r <= q_per;
      dly_r <= clamped;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FULL || state_r == S_ACK || state_r == S_READ) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state_r == S_FULL) begin
        out_kind_r   <= twt_pkg::KIND_ACK;
        out_id_r     <= '0;
        out_status_r <= twt_pkg::STATUS_FULL;
        out_last_r   <= 1'b1;
      end else if (state_r == S_ACK) begin
        out_kind_r   <= twt_pkg::KIND_ACK;
        out_id_r     <= id_r;
        out_status_r <= twt_pkg::STATUS_OK;
        out_last_r   <= 1'b1;
      end else if (state_r == S_READ) begin
        out_kind_r   <= twt_pkg::KIND_EXPIRED;
        out_id_r     <= id_r;
        out_status_r <= twt_pkg::STATUS_OK;
        out_last_r   <= emit_last;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.timer_id = twt_pkg::ID_OUT_W'(out_id_r);
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  // checks
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside a placement");

  a_emit_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> hit_r[id_r])
    else $error("expiry emitted for an entry that did not hit");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (we && !rearm_r) |-> !valid_r[id_r])
    else $error("add overwrote a live entry");

endmodule

`default_nettype wire
